>>> rtl/sc_pkg.sv
`timescale 1ns / 1ps
// shared constants, widths and types for the fixed-point sine/cosine pipeline
// no dependencies; imported by sc_fold, sc_poly and fixed_point_sine_cosine_top
package sc_pkg;

	// angular resolution, power of two
	localparam int TABLE_SIZE  = 8192;
	localparam int IDX_W       = $clog2(TABLE_SIZE);
	localparam int QUARTER     = TABLE_SIZE / 4;
	localparam int HALF        = TABLE_SIZE / 2;
	localparam int QTR_SH      = $clog2(QUARTER);
	localparam int PP_W        = IDX_W - 1;
	localparam int FOLD_W      = QTR_SH;

	localparam int FIX_ONE     = 65536;
	localparam int HALF_PI_FIX = 102944;

	// operand widths of the polynomial terms, first quadrant only
	localparam int X_W   = 17;
	localparam int X2_W  = 18;
	localparam int X3_W  = 18;
	localparam int X5_W  = 20;
	localparam int X7_W  = 21;
	localparam int Q_W   = 16;
	localparam int MAG_W = 17;
	localparam int VAL_W = 18;

	typedef struct packed {
		logic neg;
		logic force_en;
		logic force_one;
	} sc_ctl_t;

endpackage

>>> rtl/sc_fold.sv
`timescale 1ns / 1ps
// input register and quadrant fold: angle to index, cosine offset, sign and fold
// depends on sc_pkg
module sc_fold (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   accept,
	input  logic                   req_type,
	input  logic [31:0]            angle,
	output logic                   valid_s2,
	output sc_pkg::sc_ctl_t        ctl_s2,
	output logic [sc_pkg::FOLD_W-1:0] fold_s2
);
	import sc_pkg::*;

	logic              valid_s1;
	logic              req_s1;
	logic [31:0]       angle_s1;
	logic [IDX_W-1:0]  idx;
	logic [IDX_W-1:0]  p;
	logic [PP_W-1:0]   pp;
	logic [PP_W-1:0]   fold_full;
	sc_ctl_t           ctl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	always_comb begin
		idx           = angle_s1[31 -: IDX_W];
		p             = idx + (req_s1 ? IDX_W'(QUARTER) : '0);
		pp            = p[PP_W-1:0];
		fold_full     = (pp > PP_W'(QUARTER)) ? ('0 - pp) : pp;
		ctl.neg       = p[IDX_W-1];
		ctl.force_one = (pp == PP_W'(QUARTER));
		ctl.force_en  = ctl.force_one || (pp == '0);
	end

	always_ff @(posedge clk) begin
		req_s1   <= req_type;
		angle_s1 <= angle;
		ctl_s2   <= ctl;
		fold_s2  <= fold_full[FOLD_W-1:0];
	end

endmodule

>>> rtl/sc_poly.sv
`timescale 1ns / 1ps
// taylor polynomial pipeline: x scaling, odd powers, constant divides, sum and clamp
// depends on sc_pkg
module sc_poly (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     valid_s2,
	input  sc_pkg::sc_ctl_t          ctl_s2,
	input  logic [sc_pkg::FOLD_W-1:0] fold_s2,
	output logic                     valid_s9,
	output sc_pkg::sc_ctl_t          ctl_s9,
	output logic [sc_pkg::MAG_W-1:0] mag
);
	import sc_pkg::*;

	localparam int DIV_SH = 24;
	localparam logic [23:0] R6    = 24'((1 << DIV_SH) / 6);
	localparam logic [23:0] R120  = 24'((1 << DIV_SH) / 120);
	localparam logic [23:0] R5040 = 24'((1 << DIV_SH) / 5040);

	// reciprocal estimate, at most one below the true quotient
	function automatic logic [Q_W-1:0] recip(input logic [X7_W-1:0] n, input logic [23:0] r);
		logic [X7_W+23:0] prod;
		prod = (X7_W+24)'(n) * (X7_W+24)'(r);
		return prod[DIV_SH +: Q_W];
	endfunction

	function automatic logic [Q_W-1:0] div_fix(input logic [X7_W-1:0] n,
			input logic [Q_W-1:0] q0, input logic [12:0] d);
		logic [Q_W+12:0] t;
		t = ((Q_W+13)'(q0) + (Q_W+13)'(1)) * (Q_W+13)'(d);
		return (t <= (Q_W+13)'(n)) ? (q0 + Q_W'(1)) : q0;
	endfunction

	logic [6:0] valid_q;
	sc_ctl_t    ctl_s3, ctl_s4, ctl_s5, ctl_s6, ctl_s7, ctl_s8;

	logic [FOLD_W+X_W-1:0] p_x;
	logic [2*X_W-1:0]      p_x2;
	logic [X2_W+X_W-1:0]   p_x3;
	logic [X3_W+X2_W-1:0]  p_x5;
	logic [X5_W+X2_W-1:0]  p_x7;

	logic [X_W-1:0]  x_s3, x_s4, x_s5, x_s6, x_s7, x_s8, x_s9;
	logic [X2_W-1:0] x2_s4, x2_s5, x2_s6;
	logic [X3_W-1:0] x3_s5, x3_s6;
	logic [X5_W-1:0] x5_s6, x5_s7;
	logic [X7_W-1:0] x7_s7, x7_s8;
	logic [Q_W-1:0]  q3a_s6, q3_s7, q3_s8, q3_s9;
	logic [Q_W-1:0]  q5a_s7, q5_s8, q5_s9;
	logic [Q_W-1:0]  q7a_s8, q7_s9;
	logic signed [19:0] v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= {valid_q[5:0], valid_s2};
		end
	end
	assign valid_s9 = valid_q[6];

	always_comb begin
		p_x  = (FOLD_W+X_W)'(fold_s2) * (FOLD_W+X_W)'(HALF_PI_FIX);
		p_x2 = (2*X_W)'(x_s3) * (2*X_W)'(x_s3);
		p_x3 = (X2_W+X_W)'(x2_s4) * (X2_W+X_W)'(x_s4);
		p_x5 = (X3_W+X2_W)'(x3_s5) * (X3_W+X2_W)'(x2_s5);
		p_x7 = (X5_W+X2_W)'(x5_s6) * (X5_W+X2_W)'(x2_s6);
	end

	always_ff @(posedge clk) begin
		ctl_s3 <= ctl_s2;
		x_s3   <= p_x[QTR_SH +: X_W];

		ctl_s4 <= ctl_s3;
		x_s4   <= x_s3;
		x2_s4  <= p_x2[16 +: X2_W];

		ctl_s5 <= ctl_s4;
		x_s5   <= x_s4;
		x2_s5  <= x2_s4;
		x3_s5  <= p_x3[16 +: X3_W];

		ctl_s6 <= ctl_s5;
		x_s6   <= x_s5;
		x2_s6  <= x2_s5;
		x3_s6  <= x3_s5;
		x5_s6  <= p_x5[16 +: X5_W];
		q3a_s6 <= recip(X7_W'(x3_s5), R6);

		ctl_s7 <= ctl_s6;
		x_s7   <= x_s6;
		x5_s7  <= x5_s6;
		x7_s7  <= p_x7[16 +: X7_W];
		q3_s7  <= div_fix(X7_W'(x3_s6), q3a_s6, 13'd6);
		q5a_s7 <= recip(X7_W'(x5_s6), R120);

		ctl_s8 <= ctl_s7;
		x_s8   <= x_s7;
		x7_s8  <= x7_s7;
		q3_s8  <= q3_s7;
		q5_s8  <= div_fix(X7_W'(x5_s7), q5a_s7, 13'd120);
		q7a_s8 <= recip(x7_s7, R5040);

		ctl_s9 <= ctl_s8;
		x_s9   <= x_s8;
		q3_s9  <= q3_s8;
		q5_s9  <= q5_s8;
		q7_s9  <= div_fix(x7_s8, q7a_s8, 13'd5040);
	end

	always_comb begin
		v = 20'(x_s9) - 20'(q3_s9) + 20'(q5_s9) - 20'(q7_s9);
		if (v > 20'sd65536) begin
			mag = MAG_W'(FIX_ONE);
		end else if (v < 20'sd0) begin
			mag = '0;
		end else begin
			mag = v[MAG_W-1:0];
		end
	end

endmodule

>>> rtl/fixed_point_sine_cosine_top.sv
`timescale 1ns / 1ps
// top level of the fixed-point sine/cosine pipeline
// depends on sc_pkg, sc_fold and sc_poly
// a transaction passes through the fold registers s1 and s2, the polynomial stages s3 to s9 and the output register
// throughput: one transaction per cycle, set by the fully pipelined multiplier chain
// busy is always low and the result cannot be held off by the receiver
// reset clears all valid bits at once; no clearing pass is needed
module fixed_point_sine_cosine_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic                            req_type,
	input  logic [31:0]                     angle,
	output logic                            done,
	output logic signed [sc_pkg::VAL_W-1:0] value
);
	import sc_pkg::*;

	logic                 accept;
	logic                 valid_s2;
	sc_ctl_t              ctl_s2;
	logic [FOLD_W-1:0]    fold_s2;
	logic                 valid_s9;
	sc_ctl_t              ctl_s9;
	logic [MAG_W-1:0]     mag;
	logic [MAG_W-1:0]     mag_f;
	logic                 done_q;
	logic [VAL_W-1:0]     value_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	sc_fold u_fold (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.req_type (req_type),
		.angle    (angle),
		.valid_s2 (valid_s2),
		.ctl_s2   (ctl_s2),
		.fold_s2  (fold_s2)
	);

	sc_poly u_poly (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.ctl_s2   (ctl_s2),
		.fold_s2  (fold_s2),
		.valid_s9 (valid_s9),
		.ctl_s9   (ctl_s9),
		.mag      (mag)
	);

	// exact values at the quadrant points
	assign mag_f = ctl_s9.force_en ? (ctl_s9.force_one ? MAG_W'(FIX_ONE) : '0) : mag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s9;
		end
	end

	always_ff @(posedge clk) begin
		value_q <= ctl_s9.neg ? ('0 - VAL_W'(mag_f)) : VAL_W'(mag_f);
	end

	assign done  = done_q;
	assign value = $signed(value_q);

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##10 done)
		else $error("accepted transaction did not complete after ten cycles");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 10))
		else $error("result without a matching transaction");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (value >= -18'sd65536) && (value <= 18'sd65536))
		else $error("result out of range");

	a_force_one: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s9 && ctl_s9.force_en && ctl_s9.force_one && !ctl_s9.neg)
			|=> (value == 18'sd65536))
		else $error("quarter point not forced to one");

endmodule
